FILE: design/mrhc_pkg.sv
// ----------------------------------------------------------------------------
// mrhc_pkg: shared types and constants
// Function attributes, status codes and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package mrhc_pkg;

  localparam int NUM_REGIONS    = 4;
  localparam int REGION_ENTRIES = 512;
  localparam int REG_W          = $clog2(NUM_REGIONS);
  localparam int ENT_W          = $clog2(REGION_ENTRIES);
  localparam int MEM_DEPTH      = NUM_REGIONS * REGION_ENTRIES;
  localparam int MEM_W          = $clog2(MEM_DEPTH);

  // status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_OTHER     = 4'd2;
  localparam logic [3:0] ST_BAD_FUNC  = 4'd3;
  localparam logic [3:0] ST_NO_REGION = 4'd4;
  localparam logic [3:0] ST_TYPE      = 4'd5;
  localparam logic [3:0] ST_RANGE     = 4'd6;
  localparam logic [3:0] ST_NO_WRITE  = 4'd7;
  localparam logic [3:0] ST_NO_READ   = 4'd8;

  // register indexes
  localparam logic [2:0] CFG_DEVICE = 3'd0;
  localparam logic [2:0] CFG_COUNT  = 3'd1;
  localparam logic [2:0] CFG_R0     = 3'd2;
  localparam logic [2:0] CFG_R1     = 3'd3;
  localparam logic [2:0] CFG_R2     = 3'd4;
  localparam logic [2:0] CFG_R3     = 3'd5;

  // function attributes: bit0 write, bit1 multiple, bit2 word
  function automatic logic [2:0] func_attr(input logic [7:0] fc);
    logic [2:0] a;
    unique case (fc)
      8'h01, 8'h02: a = 3'd2;
      8'h03, 8'h04: a = 3'd6;
      8'h05:        a = 3'd1;
      8'h06:        a = 3'd5;
      8'h0F:        a = 3'd3;
      8'h10:        a = 3'd7;
      default:      a = 3'd0;
    endcase
    return a;
  endfunction

  // classified item handed from front to back
  typedef struct packed {
    logic        is_mark;     // attribute write item
    logic [3:0]  status;      // early status, ST_OK if scan needed
    logic [1:0]  hit;
    logic [9:0]  boff;
    logic [9:0]  bcnt;
    logic [2:0]  bitoff;
    logic [10:0] reqlen;
    logic [10:0] replen;
    logic        wr;
    logic        mul;
    logic        word;
    logic [15:0] qty;
    logic [10:0] lo;          // first entry to scan
    logic [10:0] hi;          // one past last entry
    logic [1:0]  m_region;
    logic [8:0]  m_index;
    logic [1:0]  m_bits;
  } job_t;

endpackage

FILE: design/mrhc_front.sv
// ----------------------------------------------------------------------------
// mrhc_front: header classification
// Runs the frame, address, function, region, type and range checks in a
// short sequence (region search one region a cycle) and queues the job.
// ----------------------------------------------------------------------------
module mrhc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              req_type,
  input  logic [7:0]        slave_address,
  input  logic [7:0]        function_code,
  input  logic [15:0]       start_address,
  input  logic [15:0]       quantity,
  input  logic [7:0]        frame_length,
  input  logic [1:0]        attr_region,
  input  logic [8:0]        attr_index,
  input  logic [1:0]        attr_bits,
  input  logic [7:0]        device_address,
  input  logic [2:0]        region_count,
  input  logic [26:0]       region_desc [4],
  output logic              q_valid,
  output mrhc_pkg::job_t    q_job,
  input  logic              q_ready
);
  import mrhc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0]  state;
  logic [15:0] st_addr, qty;
  logic [2:0]  attr;
  logic [2:0]  k, n;
  logic [1:0]  hit;
  job_t        job;
  job_t        job_init;

  logic [26:0] dk;
  logic [15:0] f;
  logic [9:0]  s;
  logic [16:0] span, top;
  logic        inside_r;

  // current region under search
  always_comb begin
    dk       = region_desc[k[1:0]];
    f        = dk[15:0];
    s        = dk[25:16];
    span     = dk[26] ? {8'd0, s[9:1]} : {4'd0, s, 3'd0};
    top      = {1'b0, f} + span;
    inside_r = (st_addr >= f) && ({1'b0, st_addr} < top);
  end

  // job as taken in: mark fields and any early status
  always_comb begin
    job_init          = '0;
    job_init.m_region = attr_region;
    job_init.m_index  = attr_index;
    job_init.m_bits   = attr_bits;
    if (req_type)
      job_init.is_mark = 1'b1;
    else if (frame_length < 8'd6)
      job_init.status = ST_SHORT;
    else if (slave_address != device_address && slave_address != 8'd0)
      job_init.status = ST_OTHER;
    else if (func_attr(function_code) == 3'd0)
      job_init.status = ST_BAD_FUNC;
  end

  // offsets and lengths for the matched region
  logic [26:0] d;
  logic [15:0] off;
  logic [16:0] boff_w, bcnt_w;
  logic [17:0] qsum;
  logic [15:0] data;
  logic        wr, mul, word;
  always_comb begin
    d    = region_desc[hit];
    off  = st_addr - d[15:0];
    wr   = attr[0];
    mul  = attr[1];
    word = attr[2];
    qsum = {2'd0, qty} + {15'd0, off[2:0]} - 18'd1;
    if (word) begin
      bcnt_w = {qty, 1'b0};
      boff_w = {off, 1'b0};
    end else begin
      bcnt_w = qsum[17:3] + 17'd1;
      boff_w = {4'd0, off[15:3]};
    end
    if (!mul)      data = 16'd2;
    else if (word) data = {qty[14:0], 1'b0};
    else           data = {3'd0, qty[15:3] - 13'd0} + {15'd0, |qty[2:0]};
  end

  assign busy    = (state != S_IDLE);
  assign q_valid = (state == S_PUSH);
  assign q_job   = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            job         <= job_init;
            st_addr     <= start_address;
            attr        <= func_attr(function_code);
            k           <= 3'd0;
            n           <= (region_count > 3'(NUM_REGIONS)) ? 3'(NUM_REGIONS) : region_count;
            qty         <= func_attr(function_code) == 3'd0 ? quantity :
                           (func_attr(function_code) & 3'd2) != 3'd0 ? quantity : 16'd1;
            if (job_init.is_mark || job_init.status != ST_OK) state <= S_PUSH;
            else state <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (k >= n) begin
            job.status <= ST_NO_REGION;
            state      <= S_PUSH;
          end else if (inside_r) begin
            hit   <= k[1:0];
            state <= S_CALC;
          end else begin
            k <= k + 3'd1;
          end
        end
        S_CALC: begin
          state <= S_PUSH;
          if (word != d[26]) job.status <= ST_TYPE;
          else if (qty == 16'd0) job.status <= ST_RANGE;
          else if ({1'b0, boff_w} + {1'b0, bcnt_w} > {8'd0, d[25:16]})
            job.status <= ST_RANGE;
          else begin
            job.hit    <= hit;
            job.boff   <= boff_w[9:0];
            job.bcnt   <= bcnt_w[9:0];
            job.bitoff <= word ? 3'd0 : off[2:0];
            job.reqlen <= (wr && mul) ? data[10:0] + 11'd9 : 11'd8;
            job.replen <= wr ? ((mul && word) ? 11'd8 : 11'd9)
                             : data[10:0] + {10'd0, data[0]} + (word ? 11'd5 : 11'd7);
            job.wr     <= wr;
            job.mul    <= mul;
            job.word   <= word;
            job.qty    <= qty;
            job.lo     <= word ? {2'd0, boff_w[9:1]} : {1'b0, boff_w[9:0]};
            job.hi     <= word ? {2'd0, boff_w[9:1]} + {2'd0, bcnt_w[9:1]}
                               : {1'b0, boff_w[9:0]} + {1'b0, bcnt_w[9:0]};
          end
        end
        S_PUSH: begin
          if (q_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: design/mrhc_queue.sv
// ----------------------------------------------------------------------------
// mrhc_queue: two-entry job queue
// Decouples the classifier from the mark scanner.
// ----------------------------------------------------------------------------
module mrhc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  mrhc_pkg::job_t in_job,
  output logic           in_ready,
  output logic           out_valid,
  output mrhc_pkg::job_t out_job,
  input  logic           out_ready
);
  import mrhc_pkg::*;

  job_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_job   = mem[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_job;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: design/mrhc_back.sv
// ----------------------------------------------------------------------------
// mrhc_back: access mark store and scan
// Clears the mark memory after reset, writes marks and scans a request's
// entries in turn (read, then check), strobing the result before the next job.
// ----------------------------------------------------------------------------
module mrhc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  mrhc_pkg::job_t q_job,
  output logic           q_ready,
  output logic           clearing,
  output logic           done,
  output logic [3:0]     status,
  output logic [1:0]     region_hit,
  output logic [9:0]     byte_offset,
  output logic [9:0]     byte_count,
  output logic [2:0]     bit_offset,
  output logic [10:0]    expected_request_length,
  output logic [10:0]    reply_length,
  output logic           is_write,
  output logic           is_multiple,
  output logic           is_word,
  output logic [15:0]    effective_quantity
);
  import mrhc_pkg::*;

  localparam logic [2:0] B_CLR  = 3'd0;
  localparam logic [2:0] B_IDLE = 3'd1;
  localparam logic [2:0] B_RD   = 3'd2;
  localparam logic [2:0] B_CHK  = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  logic [1:0]     marks [MEM_DEPTH];
  logic [2:0]     state;
  logic [MEM_W:0] clr;
  job_t           job;
  logic [10:0]    i;
  logic [1:0]     rdata;
  logic           rd_in;
  logic [3:0]     fin;

  logic           we;
  logic [MEM_W-1:0] waddr, raddr;
  logic [1:0]     wdata;

  // mark write port: clearing sweep or mark item
  always_comb begin
    we    = 1'b0;
    waddr = clr[MEM_W-1:0];
    wdata = 2'd0;
    if (state == B_CLR) we = 1'b1;
    else if (state == B_IDLE && q_valid && q_job.is_mark &&
             {1'b0, q_job.m_index} < 10'(REGION_ENTRIES)) begin
      we    = 1'b1;
      waddr = MEM_W'({q_job.m_region, ENT_W'(q_job.m_index)});
      wdata = q_job.m_bits;
    end
    raddr = MEM_W'({job.hit, ENT_W'(i)});
  end

  always_ff @(posedge clk) begin
    if (we) marks[waddr] <= wdata;
    rdata <= marks[raddr];
  end

  assign q_ready  = (state == B_IDLE);
  assign clearing = (state == B_CLR);
  assign done     = (state == B_OUT);

  // results other than status, zero unless ok
  always_comb begin
    logic ok;
    ok = (fin == ST_OK) && !job.is_mark;
    status                  = fin;
    region_hit              = ok ? job.hit : 2'd0;
    byte_offset             = ok ? job.boff : 10'd0;
    byte_count              = ok ? job.bcnt : 10'd0;
    bit_offset              = ok ? job.bitoff : 3'd0;
    expected_request_length = ok ? job.reqlen : 11'd0;
    reply_length            = ok ? job.replen : 11'd0;
    is_write                = ok ? job.wr : 1'b0;
    is_multiple             = ok ? job.mul : 1'b0;
    is_word                 = ok ? job.word : 1'b0;
    effective_quantity      = ok ? job.qty : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLR;
      clr   <= '0;
    end else begin
      unique case (state)
        B_CLR: begin
          clr <= clr + 1'b1;
          if (clr == (MEM_W+1)'(MEM_DEPTH - 1)) state <= B_IDLE;
        end
        B_IDLE: begin
          if (q_valid) begin
            job <= q_job;
            i   <= q_job.lo;
            fin <= q_job.status;
            if (q_job.is_mark || q_job.status != ST_OK) state <= B_OUT;
            else state <= B_RD;
          end
        end
        B_RD: begin
          // scan finished with all marks present
          if (i >= job.hi) state <= B_OUT;
          else begin
            rd_in <= (i < 11'(REGION_ENTRIES));
            state <= B_CHK;
          end
        end
        B_CHK: begin
          if (!rd_in || (rdata & (job.wr ? 2'd2 : 2'd1)) == 2'd0) begin
            fin   <= job.wr ? ST_NO_WRITE : ST_NO_READ;
            state <= B_OUT;
          end else begin
            i     <= i + 11'd1;
            state <= B_RD;
          end
        end
        B_OUT: state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule

FILE: design/modbus_rtu_request_header_check.sv
// ----------------------------------------------------------------------------
// modbus_rtu_request_header_check: Modbus RTU request header validation
// Checks one request header per item, or writes one access mark entry.
// ----------------------------------------------------------------------------
// Items enter on start while busy is low. Each item gives one result, shown
// for one cycle with done high; the receiver cannot stall it. Registers are
// written through cfg_valid/cfg_ready/cfg_index/cfg_data, always ready.
// Frame, address and function failures and mark items go from the classifier
// through the queue straight to done; other requests first run the region
// search, one region tried after another, then the type and range check,
// before any mark scan. The scan reads and then checks each entry (one
// memory read port); it stops at the first entry past the mark store. The
// classifier can accept the next item once it has queued the last one, while
// the scanner works, up to two jobs queued; a full queue holds busy high.
// After reset the mark memory is cleared one entry a cycle, all 2048 entries,
// with busy high; registers return to their reset values at once.
// ----------------------------------------------------------------------------
module modbus_rtu_request_header_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [7:0]  slave_address,
  input  logic [7:0]  function_code,
  input  logic [15:0] start_address,
  input  logic [15:0] quantity,
  input  logic [7:0]  frame_length,
  input  logic [1:0]  attr_region,
  input  logic [8:0]  attr_index,
  input  logic [1:0]  attr_bits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [26:0] cfg_data,
  output logic        done,
  output logic [3:0]  status,
  output logic [1:0]  region_hit,
  output logic [9:0]  byte_offset,
  output logic [9:0]  byte_count,
  output logic [2:0]  bit_offset,
  output logic [10:0] expected_request_length,
  output logic [10:0] reply_length,
  output logic        is_write,
  output logic        is_multiple,
  output logic        is_word,
  output logic [15:0] effective_quantity
);
  import mrhc_pkg::*;

  logic [7:0]  device_address;
  logic [2:0]  region_count;
  logic [26:0] region_desc [4];

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'd1;
      region_count   <= 3'd0;
      region_desc    <= '{default: 27'd0};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEVICE: device_address <= cfg_data[7:0];
        CFG_COUNT:  region_count   <= cfg_data[2:0];
        CFG_R0:     region_desc[0] <= cfg_data;
        CFG_R1:     region_desc[1] <= cfg_data;
        CFG_R2:     region_desc[2] <= cfg_data;
        CFG_R3:     region_desc[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic f_busy, clearing;
  logic fq_valid, fq_ready, bq_valid, bq_ready;
  job_t fq_job, bq_job;

  assign busy = f_busy || clearing;

  mrhc_front u_front (
    .clk, .rst,
    .start(start && !clearing), .busy(f_busy),
    .req_type, .slave_address, .function_code, .start_address, .quantity,
    .frame_length, .attr_region, .attr_index, .attr_bits,
    .device_address, .region_count, .region_desc,
    .q_valid(fq_valid), .q_job(fq_job), .q_ready(fq_ready)
  );

  mrhc_queue u_queue (
    .clk, .rst,
    .in_valid(fq_valid), .in_job(fq_job), .in_ready(fq_ready),
    .out_valid(bq_valid), .out_job(bq_job), .out_ready(bq_ready)
  );

  mrhc_back u_back (
    .clk, .rst,
    .q_valid(bq_valid), .q_job(bq_job), .q_ready(bq_ready),
    .clearing, .done,
    .status, .region_hit, .byte_offset, .byte_count, .bit_offset,
    .expected_request_length, .reply_length, .is_write, .is_multiple,
    .is_word, .effective_quantity
  );
endmodule
